FILE: design/sse_pkg.sv
`timescale 1ns / 1ps

package sse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic  valid;
    data_t value;
    logic  ins;    // incoming value belongs at or before this cell
  } cell_link_t;

  // per-cycle command broadcast along the chain
  typedef struct packed {
    logic  insert;
    logic  drain;
    data_t value;
  } cell_ctl_t;

  localparam cell_link_t LINK_IDLE = '{valid: 1'b0, value: '0, ins: 1'b0};

endpackage

FILE: design/sse_cell.sv
`timescale 1ns / 1ps

module sse_cell
  import sse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  cell_link_t prev_link,
  input  cell_link_t next_link,
  output cell_link_t link
);

  logic  valid_r;
  logic  valid_nxt;
  data_t value_r;
  data_t value_nxt;
  logic  ins;

  // empty cells and larger held values make room for the new value
  assign ins = !valid_r || (ctl.value < value_r);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctl.insert && ins) begin
      if (prev_link.ins) begin
        valid_nxt = prev_link.valid;
        value_nxt = prev_link.value;
      end else begin
        valid_nxt = 1'b1;
        value_nxt = ctl.value;
      end
    end else if (ctl.drain) begin
      valid_nxt = next_link.valid;
      value_nxt = next_link.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign link = '{valid: valid_r, value: value_r, ins: ins};

endmodule

FILE: design/selection_sort_engine.sv
`timescale 1ns / 1ps

// selection_sort_engine: sorts a set of signed 32-bit values in ascending order
// - input channel (in_valid/in_ready): one value per transfer, in_end_of_set
//   marks the final value of a set
// - result channel (out_valid/out_ready): the set in ascending order, one value
//   per transfer, out_end_of_run on the last, out_overflowed on every result
//   of a set that lost values past MAX_ITEMS
// - values sort while they load: a chain of MAX_ITEMS cells keeps the set in
//   order, each new value taking its place as it is transferred, so in_ready
//   stays high while the set loads
// - the first result is valid the cycle after the end-of-set transfer; the
//   chain then shifts toward cell 0 on each result transfer, one result per
//   cycle while out_ready is high
// - in_ready is low while the set drains; it returns the cycle after the last
//   result is transferred
// - a receiver stall holds the chain and the current result unchanged
// - reset empties the chain and clears count and overflow state; no clearing
//   pass is needed
module selection_sort_engine
  import sse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] in_data_value,
  input  logic              in_end_of_set,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [31:0] out_sorted_value,
  output logic              out_end_of_run,
  output logic              out_overflowed
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic             draining_r;
  logic             draining_nxt;
  logic             overflow_r;
  logic             overflow_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic       in_xfer;
  logic       out_xfer;
  logic       full;
  cell_ctl_t  ctl;
  cell_link_t links [MAX_ITEMS];

  assign in_ready = !draining_r;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign full     = (count_r == CNT_W'(MAX_ITEMS));

  // values past the chain length are dropped and flagged
  assign ctl = '{insert: in_xfer && !full, drain: out_xfer, value: in_data_value};

  // cell 0 holds the smallest value and feeds the result port
  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      cell_link_t prev_link;
      cell_link_t next_link;
      if (gi == 0) begin : g_head
        assign prev_link = LINK_IDLE;
      end else begin : g_body_prev
        assign prev_link = links[gi-1];
      end
      if (gi == MAX_ITEMS - 1) begin : g_tail
        assign next_link = LINK_IDLE;
      end else begin : g_body_next
        assign next_link = links[gi+1];
      end
      sse_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .prev_link (prev_link),
        .next_link (next_link),
        .link      (links[gi])
      );
    end
  endgenerate

  assign out_valid        = draining_r && links[0].valid;
  assign out_sorted_value = links[0].value;
  assign out_end_of_run   = !links[1].valid;
  assign out_overflowed   = overflow_r;

  always_comb begin
    draining_nxt = draining_r;
    overflow_nxt = overflow_r;
    count_nxt    = count_r;
    if (in_xfer) begin
      if (full) begin
        overflow_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (in_end_of_set) begin
        draining_nxt = 1'b1;
        count_nxt    = '0;
      end
    end
    // last result gone: chain is empty again
    if (out_xfer && out_end_of_run) begin
      draining_nxt = 1'b0;
      overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      overflow_r <= 1'b0;
      count_r    <= '0;
    end else begin
      draining_r <= draining_nxt;
      overflow_r <= overflow_nxt;
      count_r    <= count_nxt;
    end
  end

  // results never overlap loading
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("result valid while input ready");

  // end of set always yields a first result next cycle
  a_end_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_end_of_set) |=> out_valid)
    else $error("no result after end of set");

  // last result returns the block to loading
  a_run_end_reloads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_end_of_run) |=> (in_ready && !out_valid && !out_overflowed))
    else $error("block not idle after last result");

  // fill count never passes chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond chain length");

endmodule
